### rtl/core/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

	localparam int KEY_W  = 24;
	localparam int VAL_W  = 16;
	localparam int IDX_W  = 9;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 10;

	// home slot reduction: key bits consumed per cycle
	localparam int MOD_BITS = 8;
	localparam int MOD_CYC  = KEY_W / MOD_BITS;
	localparam int MCNT_W   = $clog2(MOD_CYC);

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic load;      // take the input beat
		logic mod_step;  // one slice of the key modulo
		logic clr_step;  // clear one slot
		logic advance;   // move to the next probe slot
		logic capture;   // latch result of the current probe
		logic push;      // move latched result to the output register
	} cmd_t;

	typedef struct packed {
		logic mod_skip;  // table size is a power of two
		logic mod_last;
		logic clr_last;
		logic finish;    // current probe ends the walk
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/lpht_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/lpht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire lpht_pkg::sts_t sts,
	output lpht_pkg::cmd_t     cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_MOD   = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.mod_skip ? S_READ : S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.finish) begin
					cmd.capture = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_READ;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/lpht_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp #(
	parameter int TABLE_SLOTS = 512
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lpht_pkg::cmd_t                cmd,
	output lpht_pkg::sts_t                     sts,
	input  wire logic                          in_op,
	input  wire logic [lpht_pkg::KEY_W-1:0]    in_key,
	input  wire logic [lpht_pkg::VAL_W-1:0]    in_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [lpht_pkg::STAT_W-1:0]   out_status,
	output logic      [lpht_pkg::VAL_W-1:0]    out_value,
	output logic      [lpht_pkg::IDX_W-1:0]    out_index
);

	localparam int  AW    = $clog2(TABLE_SLOTS);
	localparam int  RW    = 1 + lpht_pkg::KEY_W + lpht_pkg::VAL_W;
	localparam bit  POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);
	localparam logic [AW:0]   NSLOTS    = (AW + 1)'(TABLE_SLOTS);

	logic                        op_q;
	logic [lpht_pkg::KEY_W-1:0]  key_q;
	logic [lpht_pkg::KEY_W-1:0]  mkey_q;
	logic [lpht_pkg::VAL_W-1:0]  val_q;
	logic [AW-1:0]               pos_q;
	logic [AW-1:0]               lap_q;
	logic [AW-1:0]               clr_q;
	logic [lpht_pkg::MCNT_W-1:0] mcnt_q;
	logic [lpht_pkg::CNT_W-1:0]  entry_count_q;

	logic [lpht_pkg::STAT_W-1:0] res_status_q;
	logic [lpht_pkg::VAL_W-1:0]  res_value_q;
	logic [lpht_pkg::IDX_W-1:0]  res_index_q;
	logic                        out_valid_q;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [RW-1:0]               ram_wdata;
	logic [RW-1:0]               ram_rdata;

	logic                        slot_used;
	logic                        key_hit;
	logic                        is_insert;
	logic [AW-1:0]               mod_next;
	logic [lpht_pkg::STAT_W-1:0] res_status;
	logic [lpht_pkg::VAL_W-1:0]  res_value;
	logic [lpht_pkg::IDX_W-1:0]  res_index;

	// remainder of the key, MSB first, MOD_BITS compare-subtract steps per cycle
	always_comb begin
		logic [AW:0]   t;
		logic [AW-1:0] r;
		r = pos_q;
		for (int i = 0; i < lpht_pkg::MOD_BITS; i++) begin
			t = {r, mkey_q[lpht_pkg::KEY_W-1-i]};
			if (t >= NSLOTS) begin
				t = t - NSLOTS;
			end
			r = t[AW-1:0];
		end
		mod_next = r;
	end

	assign slot_used = ram_rdata[RW-1];
	assign key_hit   = slot_used
		&& (ram_rdata[lpht_pkg::VAL_W +: lpht_pkg::KEY_W] == key_q);
	assign is_insert = (op_q == lpht_pkg::OP_INSERT);

	always_comb begin
		res_status = lpht_pkg::ST_NOT_FOUND;
		res_value  = '0;
		res_index  = '0;
		if (is_insert) begin
			if (!slot_used) begin
				res_status = lpht_pkg::ST_OK;
				res_index  = lpht_pkg::IDX_W'(pos_q);
			end else begin
				res_status = lpht_pkg::ST_FULL;
			end
		end else if (key_hit) begin
			res_status = lpht_pkg::ST_OK;
			res_value  = ram_rdata[lpht_pkg::VAL_W-1:0];
			res_index  = lpht_pkg::IDX_W'(pos_q);
		end
	end

	assign sts.mod_skip = POW2;
	assign sts.mod_last = (mcnt_q == lpht_pkg::MCNT_W'(lpht_pkg::MOD_CYC - 1));
	assign sts.clr_last = (clr_q == LAST_SLOT);
	assign sts.finish   = !slot_used || (!is_insert && key_hit) || (lap_q == LAST_SLOT);
	assign sts.out_free = !out_valid_q || out_ready;

	assign ram_we    = cmd.clr_step || (cmd.capture && is_insert && !slot_used);
	assign ram_waddr = cmd.clr_step ? clr_q : pos_q;
	assign ram_wdata = cmd.clr_step ? '0 : {1'b1, key_q, val_q};

	lpht_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q         <= '0;
			mcnt_q        <= '0;
			lap_q         <= '0;
			entry_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load) begin
				mcnt_q <= '0;
				lap_q  <= '0;
			end else begin
				if (cmd.mod_step) begin
					mcnt_q <= mcnt_q + 1'b1;
				end
				if (cmd.advance) begin
					lap_q <= lap_q + 1'b1;
				end
			end
			if (cmd.capture && is_insert && !slot_used) begin
				entry_count_q <= entry_count_q + 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			key_q  <= in_key;
			mkey_q <= in_key;
			val_q  <= in_value;
			pos_q  <= POW2 ? in_key[AW-1:0] : '0;
		end else if (cmd.mod_step) begin
			pos_q  <= mod_next;
			mkey_q <= mkey_q << lpht_pkg::MOD_BITS;
		end else if (cmd.advance) begin
			pos_q <= (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;
		end
		if (cmd.capture) begin
			res_status_q <= res_status;
			res_value_q  <= res_value;
			res_index_q  <= res_index;
		end
		if (cmd.push) begin
			out_status <= res_status_q;
			out_value  <= res_value_q;
			out_index  <= res_index_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/linear_probe_hash_table_core.sv
// channel | dir | tdata (low bit up)                  | tuser
// s_*     | in  | key[23:0], entry_value[39:24]       | op[0]
// m_*     | out | found_value[15:0], slot_index[24:16] | status[1:0]
//
// One item at a time: an accept state, the key modulo in slices (none when
// TABLE_SLOTS is a power of two), a registered RAM read then a compare for
// each probed slot, and a move to the output register. After reset a
// clearing pass writes every slot with s_tready low. A result waiting on
// m_tready holds in the output register while the next beat is accepted.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_core #(
	parameter int TABLE_SLOTS = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // key[23:0], entry_value[39:24]
	input  wire logic [0:0]  s_tuser,   // op[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // found_value[15:0], slot_index[24:16], zero
	output logic      [1:0]  m_tuser    // status[1:0]
);

	lpht_pkg::cmd_t cmd;
	lpht_pkg::sts_t sts;

	logic [lpht_pkg::VAL_W-1:0] out_value;
	logic [lpht_pkg::IDX_W-1:0] out_index;

	lpht_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lpht_dp #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (s_tuser[0]),
		.in_key    (s_tdata[23:0]),
		.in_value  (s_tdata[39:24]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_status(m_tuser),
		.out_value (out_value),
		.out_index (out_index)
	);

	assign m_tdata = {7'b0, out_index, out_value};

endmodule

`default_nettype wire

### rtl/core/lpht_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	logic       s_beat;
	logic       m_beat;
	logic [1:0] pending_q;

	assign s_beat = s_tvalid && s_tready;
	assign m_beat = m_tvalid && m_tready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (s_beat && !m_beat) begin
			pending_q <= pending_q + 1'b1;
		end else if (m_beat && !s_beat) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> !s_tready)
		else $error("input accepted on back-to-back cycles");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != 2'd3) && (!m_tvalid || pending_q != 2'd0))
		else $error("result count does not match accepted items");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != lpht_pkg::ST_OK) |-> (m_tdata == 32'd0))
		else $error("non-ok result carries value or index");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind linear_probe_hash_table_core lpht_checker u_chk (.*);

`default_nettype wire

### verif/linear_probe_hash_table_core_tb.sv
`timescale 1ns / 1ps

module linear_probe_hash_table_core_tb;

	localparam int SLOTS = 512;
	// worst single item: one full lap of probes plus output register
	localparam int LAP_CYCLES = 4 + 2 * SLOTS + 64;

	typedef struct packed {
		logic [lpht_pkg::STAT_W-1:0] status;
		logic [lpht_pkg::VAL_W-1:0]  found_value;
		logic [lpht_pkg::IDX_W-1:0]  slot_index;
	} probe_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // key[23:0], entry_value[39:24]
	logic [0:0]  s_tuser = '0;   // op[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // found_value[15:0], slot_index[24:16], zero
	logic [1:0]  m_tuser;        // status[1:0]

	// shadow of the table contents
	bit                         tbl_valid [SLOTS];
	logic [lpht_pkg::KEY_W-1:0] tbl_key [SLOTS];
	logic [lpht_pkg::VAL_W-1:0] tbl_val [SLOTS];
	int                         slots_used;

	probe_result_t              pending_results[$];
	logic [lpht_pkg::KEY_W-1:0] stored_keys[$];
	probe_result_t              exp_r;

	int send_idle_pct;
	int stall_pct;
	int lookups_sent;
	int inserts_sent;
	int results_checked;
	int mismatches;

	linear_probe_hash_table_core #(
		.TABLE_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// walk the shadow table exactly as the block should, updating it on insert
	function automatic void probe_table(input logic op, input logic [lpht_pkg::KEY_W-1:0] key,
			input logic [lpht_pkg::VAL_W-1:0] val, output probe_result_t res);
		int unsigned pos;
		int unsigned n;
		bit done;
		pos = key % SLOTS;
		done = 1'b0;
		res.status = (op == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
		res.found_value = '0;
		res.slot_index = '0;
		for (n = 0; n < SLOTS && !done; n++) begin
			if (!tbl_valid[pos]) begin
				done = 1'b1;
				if (op == lpht_pkg::OP_INSERT) begin
					tbl_valid[pos] = 1'b1;
					tbl_key[pos] = key;
					tbl_val[pos] = val;
					slots_used++;
					res.status = lpht_pkg::ST_OK;
					res.slot_index = pos[lpht_pkg::IDX_W-1:0];
				end else begin
					res.status = lpht_pkg::ST_NOT_FOUND;
				end
			end else if (op == lpht_pkg::OP_LOOKUP && tbl_key[pos] == key) begin
				done = 1'b1;
				res.status = lpht_pkg::ST_OK;
				res.found_value = tbl_val[pos];
				res.slot_index = pos[lpht_pkg::IDX_W-1:0];
			end
			pos = (pos + 1) % SLOTS;
		end
	endfunction

	function automatic bit key_stored(input logic [lpht_pkg::KEY_W-1:0] key);
		bit hit;
		hit = 1'b0;
		foreach (tbl_valid[i])
			if (tbl_valid[i] && tbl_key[i] == key)
				hit = 1'b1;
		return hit;
	endfunction

	// keys biased toward a few crowded homes, including the ones next to the wrap, or repeating a stored key
	function automatic logic [lpht_pkg::KEY_W-1:0] pick_key();
		logic [lpht_pkg::KEY_W-1:0] k;
		int sel;
		k = 24'($urandom);
		sel = $urandom_range(9);
		if (sel >= 4 && sel <= 6) begin
			if ($urandom_range(1))
				k[8:0] = 9'($urandom_range(0, 7));
			else
				k[8:0] = 9'($urandom_range(SLOTS - 8, SLOTS - 1));
		end else if (sel >= 7 && stored_keys.size() != 0) begin
			k = stored_keys[$urandom_range(stored_keys.size() - 1)];
		end
		return k;
	endfunction

	function automatic logic [lpht_pkg::KEY_W-1:0] known_key();
		return stored_keys[$urandom_range(stored_keys.size() - 1)];
	endfunction

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	// called at a rising edge; returns at the edge where the beat is taken
	task automatic send_request(input logic op, input logic [lpht_pkg::KEY_W-1:0] key,
			input logic [lpht_pkg::VAL_W-1:0] val);
		int gap;
		probe_result_t res;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {val, key};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		probe_table(op, key, val, res);
		pending_results.push_back(res);
		if (op == lpht_pkg::OP_INSERT) begin
			inserts_sent++;
			if (res.status == lpht_pkg::ST_OK)
				stored_keys.push_back(key);
		end else begin
			lookups_sent++;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		set_idling(0, 0);
		send_request(lpht_pkg::OP_LOOKUP, 24'h000000, 16'h0000);
		send_request(lpht_pkg::OP_LOOKUP, 24'hFFFFFF, 16'hFFFF);
		send_request(lpht_pkg::OP_INSERT, 24'h000000, 16'h0000);
		send_request(lpht_pkg::OP_INSERT, 24'hFFFFFF, 16'hFFFF);
		send_request(lpht_pkg::OP_INSERT, 24'h000200, 16'h1234);
		// duplicate of the top key: home is the last slot, walk wraps to slot 0
		send_request(lpht_pkg::OP_INSERT, 24'hFFFFFF, 16'hAAAA);
		send_request(lpht_pkg::OP_LOOKUP, 24'hFFFFFF, 16'h0000);
		send_request(lpht_pkg::OP_LOOKUP, 24'h000200, 16'h0000);
		send_request(lpht_pkg::OP_LOOKUP, 24'h000400, 16'h0000);
		send_request(lpht_pkg::OP_LOOKUP, 24'h000000, 16'hFFFF);
		send_request(lpht_pkg::OP_INSERT, 24'h5555AA, 16'h5555);
		send_request(lpht_pkg::OP_INSERT, 24'hAA5555, 16'hAAAA);
		send_request(lpht_pkg::OP_LOOKUP, 24'h5555AA, 16'h0000);
		send_request(lpht_pkg::OP_LOOKUP, 24'hAA5555, 16'h0000);
		send_request(lpht_pkg::OP_LOOKUP, 24'hAA55AA, 16'h0000);
		send_request(lpht_pkg::OP_INSERT, 24'h7FFE00, 16'h8001);
		send_request(lpht_pkg::OP_LOOKUP, 24'h7FFE00, 16'h0000);
	endtask

	task automatic test_random_mix();
		int i;
		for (i = 0; i < 240; i++) begin
			case (i / 60)
				0: set_idling(0, 0);
				1: set_idling(85, 0);
				2: set_idling(0, 85);
				default: set_idling(18, 18);
			endcase
			if ($urandom_range(1))
				send_request(lpht_pkg::OP_INSERT, pick_key(), 16'($urandom));
			else if ($urandom_range(9) < 6)
				send_request(lpht_pkg::OP_LOOKUP, known_key(), 16'($urandom));
			else
				send_request(lpht_pkg::OP_LOOKUP, pick_key(), 16'($urandom));
			if ($urandom_range(39) == 0)
				drain();
		end
	endtask

	task automatic test_fill_to_capacity();
		int i;
		i = 0;
		while (slots_used < SLOTS) begin
			case ((i / 50) % 4)
				0: set_idling(18, 18);
				1: set_idling(0, 85);
				2: set_idling(85, 0);
				default: set_idling(0, 0);
			endcase
			if ($urandom_range(7) == 0)
				send_request(lpht_pkg::OP_LOOKUP,
					($urandom_range(1)) ? known_key() : pick_key(), 16'($urandom));
			else
				send_request(lpht_pkg::OP_INSERT, pick_key(), 16'($urandom));
			i++;
		end
	endtask

	task automatic test_full_table();
		logic [lpht_pkg::KEY_W-1:0] absent;
		absent = 24'($urandom);
		while (key_stored(absent))
			absent = 24'($urandom);
		set_idling(18, 18);
		send_request(lpht_pkg::OP_INSERT, 24'h000000, 16'hFFFF);
		send_request(lpht_pkg::OP_INSERT, 24'($urandom), 16'($urandom));
		send_request(lpht_pkg::OP_LOOKUP, absent, 16'h0000);
		send_request(lpht_pkg::OP_LOOKUP, stored_keys[0], 16'h0000);
		send_request(lpht_pkg::OP_LOOKUP, stored_keys[stored_keys.size() - 1], 16'h0000);
		send_request(lpht_pkg::OP_LOOKUP, 24'hFFFFFF, 16'h0000);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: status %0d tdata %h",
					m_tuser, m_tdata);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				results_checked++;
				if (m_tuser !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, m_tuser);
					mismatches++;
				end
				if (m_tdata[15:0] !== exp_r.found_value) begin
					$error("found_value: expected %h, got %h",
						exp_r.found_value, m_tdata[15:0]);
					mismatches++;
				end
				if (m_tdata[24:16] !== exp_r.slot_index) begin
					$error("slot_index: expected %0d, got %0d",
						exp_r.slot_index, m_tdata[24:16]);
					mismatches++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		slots_used = 0;
		lookups_sent = 0;
		inserts_sent = 0;
		results_checked = 0;
		mismatches = 0;
		set_idling(0, 0);
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		drain();
		test_random_mix();
		drain();
		test_fill_to_capacity();
		drain();
		test_full_table();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LAP_CYCLES) @(posedge clk);

		$display("Sent %0d lookups and %0d inserts; %0d results compared.",
			lookups_sent, inserts_sent, results_checked);
		$display("Table filled to %0d of %0d slots, with collisions, wrap and full-lap walks.",
			slots_used, SLOTS);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### linear_probe_hash_table_core.f
rtl/core/lpht_pkg.sv
rtl/core/lpht_ram.sv
rtl/core/lpht_ctrl.sv
rtl/core/lpht_dp.sv
rtl/core/linear_probe_hash_table_core.sv
rtl/core/lpht_checker.sv
verif/linear_probe_hash_table_core_tb.sv
